>>> rtl/lcpd_pkg.sv
// Shared types and constants of the light command packet decoder.
package lcpd_pkg;

  localparam int HdrDepth = 13;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] capture_time;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  kind_code;
    logic [15:0] function_code;
    logic [7:0]  mask_value;
    logic [7:0]  palette_a;
    logic [7:0]  palette_b;
    logic [7:0]  palette_c;
    logic [4:0]  palette_d;
    logic [4:0]  palette_e;
    logic [2:0]  palette_total;
    logic        raw_fallback;
    logic [31:0] stamp_out;
  } out_word_t;

  // One finished payload as handed from the front to the back.
  typedef struct packed {
    logic [HdrDepth-1:0][7:0] hdr;
    logic [7:0]               len;
    logic [31:0]              stamp;
  } frame_t;

  localparam logic [3:0] KIND_UNKNOWN      = 4'd0;
  localparam logic [3:0] KIND_UNCLASSIFIED = 4'd1;
  localparam logic [3:0] KIND_SINGLE       = 4'd2;
  localparam logic [3:0] KIND_DUAL         = 4'd3;
  localparam logic [3:0] KIND_RGB          = 4'd4;
  localparam logic [3:0] KIND_FIVE         = 4'd5;
  localparam logic [3:0] KIND_PALETTE      = 4'd6;
  localparam logic [3:0] KIND_ANIMATION    = 4'd7;
  localparam logic [3:0] KIND_FLASH        = 4'd8;

  localparam logic [15:0] FN_SINGLE    = 16'hE905;
  localparam logic [15:0] FN_DUAL      = 16'hE906;
  localparam logic [15:0] FN_RGB       = 16'hE908;
  localparam logic [15:0] FN_FIVE      = 16'hE909;
  localparam logic [15:0] FN_ANIMATION = 16'hE90C;
  localparam logic [15:0] FN_FLASH     = 16'hE90E;

  localparam logic [7:0] BYTE_WAKE     = 8'hCC;
  localparam logic [7:0] BYTE_WAKE_SUB = 8'h03;
  localparam logic [7:0] BYTE_FAMILY   = 8'hE9;
  localparam logic [7:0] BYTE_WRAP_1   = 8'hE1;
  localparam logic [7:0] BYTE_WRAP_2   = 8'hE2;
  localparam logic [7:0] BYTE_MODE_E   = 8'h0E;
  localparam logic [7:0] BYTE_MODE_F   = 8'h0F;
  localparam logic [2:0] SLOT_TAG      = 3'b101;

endpackage

>>> rtl/lcpd_front.sv
// Front end: byte capture, length count and frame snapshot on the last byte.
module lcpd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lcpd_pkg::in_word_t in_word,
  input  logic              queue_full,
  output logic              push,
  output lcpd_pkg::frame_t  frame
);
  import lcpd_pkg::*;

  logic [HdrDepth-1:0][7:0] hdr_r, hdr_nxt;
  logic [7:0]               count_r, count_nxt;
  logic                     accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  always_comb begin
    hdr_nxt = hdr_r;
    count_nxt = count_r;
    if (accept) begin
      if (count_r < 8'(HdrDepth)) begin
        hdr_nxt[count_r[3:0]] = in_word.data_byte;
      end
      if (in_word.last_byte) begin
        count_nxt = 8'd0;
      end else if (count_r != 8'hFF) begin
        count_nxt = count_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    if (!rst_n) begin
      count_r <= 8'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // The snapshot already holds the last byte itself.
  assign push        = accept && in_word.last_byte;
  assign frame.hdr   = hdr_nxt;
  assign frame.len   = (count_r == 8'hFF) ? 8'hFF : count_r + 8'd1;
  assign frame.stamp = in_word.capture_time;

endmodule

>>> rtl/lcpd_fifo.sv
// Two-entry queue of finished frames between front and back.
module lcpd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lcpd_pkg::frame_t push_frame,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output lcpd_pkg::frame_t head_frame
);
  import lcpd_pkg::*;

  frame_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_frame = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

>>> rtl/lcpd_back.sv
// Back end: classifies the frame at the queue head into the output register.
module lcpd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  lcpd_pkg::frame_t   head_frame,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lcpd_pkg::out_word_t out_word
);
  import lcpd_pkg::*;

  out_word_t out_word_r, res;
  logic      out_valid_r;

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  always_comb begin
    logic [HdrDepth-1:0][7:0] h;
    logic [7:0]  len;
    logic [15:0] fn;
    logic        anyn;
    logic        fallback;
    h   = head_frame.hdr;
    len = head_frame.len;
    fn  = {h[2], h[3]};
    anyn = 1'b0;
    for (int i = 7; i <= 11; i++) begin
      if (h[i][7:5] != SLOT_TAG) anyn = 1'b1;
    end
    fallback = 1'b0;
    res = '0;
    res.stamp_out = head_frame.stamp;

    if (len >= 8'd2 && h[0] == BYTE_WAKE && h[1] == BYTE_WAKE_SUB) begin
      res.kind_code = KIND_UNKNOWN;
    end else if (len >= 8'd5 && (h[0] == BYTE_WRAP_1 || h[0] == BYTE_WRAP_2)
                 && h[2] == BYTE_FAMILY) begin
      res.function_code = fn;
      unique case (fn)
        FN_SINGLE: begin
          if (len < 8'd9) begin
            fallback = 1'b1;
          end else begin
            res.kind_code = KIND_SINGLE;
            res.mask_value = (h[6] == BYTE_MODE_E || h[6] == BYTE_MODE_F) ?
                             {5'd0, h[7][7:5]} : h[6];
            res.palette_a = {3'd0, h[7][4:0]};
            res.palette_total = 3'd1;
          end
        end
        FN_DUAL: begin
          if (len < 8'd10) begin
            fallback = 1'b1;
          end else begin
            res.kind_code = KIND_DUAL;
            res.palette_a = h[7];
            res.palette_b = h[8];
            res.palette_total = 3'd2;
          end
        end
        FN_RGB: begin
          if (len < 8'd12) begin
            fallback = 1'b1;
          end else begin
            res.kind_code = KIND_RGB;
            res.palette_a = widen6(h[8][6:1]);
            res.palette_b = widen6(h[9][6:1]);
            res.palette_c = widen6(h[10][6:1]);
            res.palette_total = 3'd3;
          end
        end
        FN_FIVE: begin
          if (len < 8'd13) begin
            fallback = 1'b1;
          end else begin
            res.kind_code = KIND_FIVE;
            res.palette_a = {3'd0, h[7][4:0]};
            res.palette_b = {3'd0, h[8][4:0]};
            res.palette_c = {3'd0, h[9][4:0]};
            res.palette_d = h[10][4:0];
            res.palette_e = h[11][4:0];
            res.palette_total = 3'd5;
            if (anyn) res.mask_value = {5'b10000, h[7][7:5]};
          end
        end
        FN_ANIMATION: begin
          if (len >= 8'd12 && h[6] == BYTE_MODE_F && !anyn) begin
            res.kind_code = KIND_PALETTE;
            res.palette_a = {3'd0, h[7][4:0]};
            res.palette_b = {3'd0, h[8][4:0]};
            res.palette_c = {3'd0, h[9][4:0]};
            res.palette_d = h[10][4:0];
            res.palette_e = h[11][4:0];
            res.palette_total = 3'd5;
          end else begin
            res.kind_code = KIND_ANIMATION;
            res.raw_fallback = 1'b1;
          end
        end
        FN_FLASH: begin
          res.kind_code = KIND_FLASH;
        end
        default: begin
          fallback = 1'b1;
        end
      endcase
      if (fallback) begin
        res.kind_code = KIND_UNCLASSIFIED;
        res.raw_fallback = 1'b1;
      end
    end else if (len >= 8'd2 && h[0] == BYTE_FAMILY) begin
      res.kind_code = KIND_UNCLASSIFIED;
      res.function_code = {BYTE_FAMILY, h[1]};
      res.raw_fallback = 1'b1;
    end
  end

  assign pop = !empty && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word_r <= res;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/light_command_packet_decoder.sv
// Payload bytes in: one byte per cycle, sustained, while the result side keeps up.
// A last byte's frame enters the two-entry queue when the byte is accepted, and the
// classifier registers its result word from the queue head when the output is free.
// Results leave at one per cycle while out_stall is low; the queue absorbs a stall.
// Reset clears the byte count, the queue and the output valid; the header store
// is not cleared and needs no clearing pass.
module light_command_packet_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcpd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output lcpd_pkg::out_word_t out_word
);
  import lcpd_pkg::*;

  frame_t push_frame, head_frame;
  logic   push, full, pop, empty;

  lcpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .queue_full (full),
    .push       (push),
    .frame      (push_frame)
  );

  lcpd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .head_frame (head_frame)
  );

  lcpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .head_frame (head_frame),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule
